/* src/lcdnws_pkg.sv */
// Shared types, codes and strobe table for the 4-bit character LCD write sequencer.
// Used by lcdnws_ctrl, lcdnws_dp and lcd_nibble_write_sequencer.
package lcdnws_pkg;

  localparam int unsigned HalfW  = 16;
  localparam int unsigned LongW  = 24;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CfgW   = 24;

  localparam logic [HalfW-1:0] HalfReset = 16'd40;
  localparam logic [LongW-1:0] LongReset = 24'd200000;

  // Request type codes
  localparam logic [2:0] ReqInit  = 3'd0;
  localparam logic [2:0] ReqCmd   = 3'd1;
  localparam logic [2:0] ReqData  = 3'd2;
  localparam logic [2:0] ReqAddr  = 3'd3;
  localparam logic [2:0] ReqPos   = 3'd4;

  // Configuration register indexes
  localparam logic CfgHalf = 1'b0;
  localparam logic CfgLong = 1'b1;

  localparam logic [IdxW-1:0] InitLastIdx = 4'd11;
  localparam logic [IdxW-1:0] ByteLastIdx = 4'd1;

  localparam logic [7:0] SetDdramCmd = 8'h80;
  localparam logic [6:0] Line2Base   = 7'h40;

  // Nibbles of the init sequence: three wake-ups, 4-bit switch, then four commands
  localparam logic [3:0] InitNibbles [12] = '{
    4'h3, 4'h3, 4'h3, 4'h2,
    4'h2, 4'h8,          // function set 0x28
    4'h0, 4'h6,          // entry mode 0x06
    4'h0, 4'hE,          // display on, cursor on 0x0E
    4'h0, 4'h1           // clear 0x01
  };

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [6:0] column;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [1:0] wait_units;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_HIGH,
    ST_LOW,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic clr_ticks;
    logic cnt_ticks;
    logic unit_inc;
    logic next_strobe;
    logic push_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic req_empty;
    logic waits_left;
    logic unit_done;
    logic half_done;
    logic out_free;
    logic strobe_last;
  } dp_sts_t;

  function automatic out_item_t strobe_lookup(input logic            is_init,
                                              input logic [IdxW-1:0] idx,
                                              input logic            rs,
                                              input logic [7:0]      value);
    out_item_t o;
    o = '0;
    if (is_init) begin
      o.reg_select = 1'b0;
      o.nibble     = (idx <= InitLastIdx) ? InitNibbles[idx] : 4'h0;
      o.wait_units = (idx == 4'd0) ? 2'd3 : ((idx == 4'd1 || idx == 4'd2) ? 2'd1 : 2'd0);
      o.last       = (idx == InitLastIdx);
    end else begin
      o.reg_select = rs;
      o.nibble     = idx[0] ? value[3:0] : value[7:4];
      o.wait_units = 2'd0;
      o.last       = (idx == ByteLastIdx);
    end
    return o;
  endfunction

endpackage

/* src/lcdnws_ctrl.sv */
// Sequencing state machine: wait units, enable high and low phases, result hand-off.
// Depends on lcdnws_pkg; drives commands into lcdnws_dp.
module lcdnws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdnws_pkg::dp_sts_t sts,
  output lcdnws_pkg::dp_cmd_t cmd
);

  lcdnws_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcdnws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcdnws_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lcdnws_pkg::ST_START;
      end
      lcdnws_pkg::ST_START: begin
        state_nxt = sts.req_empty ? lcdnws_pkg::ST_IDLE : lcdnws_pkg::ST_WAIT;
      end
      lcdnws_pkg::ST_WAIT: begin
        if (!sts.waits_left) state_nxt = lcdnws_pkg::ST_HIGH;
      end
      lcdnws_pkg::ST_HIGH: begin
        if (sts.half_done) state_nxt = lcdnws_pkg::ST_LOW;
      end
      lcdnws_pkg::ST_LOW: begin
        if (sts.half_done) state_nxt = lcdnws_pkg::ST_EMIT;
      end
      lcdnws_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.strobe_last ? lcdnws_pkg::ST_IDLE : lcdnws_pkg::ST_WAIT;
        end
      end
      default: state_nxt = lcdnws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      lcdnws_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_req = in_valid;
      end
      lcdnws_pkg::ST_START: begin
        cmd.clr_ticks = 1'b1;
      end
      lcdnws_pkg::ST_WAIT: begin
        if (!sts.waits_left) begin
          cmd.clr_ticks = 1'b1;
        end else if (sts.unit_done) begin
          cmd.clr_ticks = 1'b1;
          cmd.unit_inc  = 1'b1;
        end else begin
          cmd.cnt_ticks = 1'b1;
        end
      end
      lcdnws_pkg::ST_HIGH, lcdnws_pkg::ST_LOW: begin
        if (sts.half_done) cmd.clr_ticks = 1'b1;
        else               cmd.cnt_ticks = 1'b1;
      end
      lcdnws_pkg::ST_EMIT: begin
        // hold the strobe until the output register can take it
        if (sts.out_free) begin
          cmd.push_out    = 1'b1;
          cmd.next_strobe = !sts.strobe_last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* src/lcdnws_dp.sv */
// Datapath: request latch, byte formation, timing counters, config and output registers.
// Depends on lcdnws_pkg; controlled by lcdnws_ctrl.
module lcdnws_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcdnws_pkg::in_item_t  in_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [lcdnws_pkg::CfgW-1:0] cfg_wdata,
  input  logic                  out_stall,
  output logic                  out_valid,
  output lcdnws_pkg::out_item_t out_data,
  input  lcdnws_pkg::dp_cmd_t   cmd,
  output lcdnws_pkg::dp_sts_t   sts
);

  logic [lcdnws_pkg::HalfW-1:0] half_r;
  logic [lcdnws_pkg::LongW-1:0] long_r;
  logic [lcdnws_pkg::LongW-1:0] ticks_r;
  logic [1:0]                   units_r;
  logic [lcdnws_pkg::IdxW-1:0]  idx_r;
  logic                         init_r;
  logic                         rs_r;
  logic [7:0]                   byte_r;
  logic                         empty_r;
  logic                         out_valid_r;
  lcdnws_pkg::out_item_t        out_data_r;

  logic [7:0]            byte_nxt;
  logic                  rs_nxt;
  logic                  empty_nxt;
  logic [6:0]            pos_addr;
  lcdnws_pkg::out_item_t strobe;

  // Decode the request into the byte to send
  always_comb begin
    pos_addr  = ((in_data.row == 2'd2) ? lcdnws_pkg::Line2Base : 7'd0)
                + in_data.column - 7'd1;
    byte_nxt  = in_data.byte_value;
    rs_nxt    = 1'b0;
    empty_nxt = 1'b0;
    case (in_data.req_type)
      lcdnws_pkg::ReqInit: byte_nxt = '0;
      lcdnws_pkg::ReqCmd:  byte_nxt = in_data.byte_value;
      lcdnws_pkg::ReqData: begin
        byte_nxt = in_data.byte_value;
        rs_nxt   = 1'b1;
      end
      lcdnws_pkg::ReqAddr: byte_nxt = lcdnws_pkg::SetDdramCmd | {1'b0, in_data.byte_value[6:0]};
      lcdnws_pkg::ReqPos: begin
        byte_nxt  = lcdnws_pkg::SetDdramCmd | {1'b0, pos_addr};
        // drop rows other than 1 and 2, and column zero
        empty_nxt = (in_data.column == 7'd0) || !(in_data.row == 2'd1 || in_data.row == 2'd2);
      end
      default: empty_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      init_r <= (in_data.req_type == lcdnws_pkg::ReqInit);
      rs_r   <= rs_nxt;
      byte_r <= byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= lcdnws_pkg::HalfReset;
      long_r      <= lcdnws_pkg::LongReset;
      ticks_r     <= '0;
      units_r     <= '0;
      idx_r       <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lcdnws_pkg::CfgHalf) half_r <= cfg_wdata[lcdnws_pkg::HalfW-1:0];
        else                                 long_r <= cfg_wdata;
      end
      if (cmd.load_req) begin
        empty_r <= empty_nxt;
        idx_r   <= '0;
        units_r <= '0;
      end else if (cmd.next_strobe) begin
        idx_r   <= idx_r + 1'b1;
        units_r <= '0;
      end else if (cmd.unit_inc) begin
        units_r <= units_r + 1'b1;
      end
      if (cmd.clr_ticks)      ticks_r <= '0;
      else if (cmd.cnt_ticks) ticks_r <= ticks_r + 1'b1;
      if (cmd.push_out)              out_valid_r <= 1'b1;
      else if (!out_stall)           out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) out_data_r <= strobe;
  end

  always_comb begin
    strobe = lcdnws_pkg::strobe_lookup(init_r, idx_r, rs_r, byte_r);
    sts.req_empty   = empty_r;
    sts.waits_left  = (units_r != strobe.wait_units);
    sts.unit_done   = (ticks_r == long_r - 1'b1);
    sts.half_done   = (ticks_r == ({{(lcdnws_pkg::LongW-lcdnws_pkg::HalfW){1'b0}}, half_r}
                                   - 1'b1));
    sts.out_free    = !out_valid_r || !out_stall;
    sts.strobe_last = strobe.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/lcd_nibble_write_sequencer.sv */
// Top level of the 4-bit character LCD write sequencer.
// Joins lcdnws_ctrl and lcdnws_dp; types from lcdnws_pkg.
//
// Usage: a request enters on in_valid/in_data while in_stall is low (init, command
// byte, data byte, set address or row/column position). Each request is expanded
// into enable strobes; one strobe is one transfer on out_valid/out_data carrying
// RS, the D7..D4 nibble, the long wait units spent before it and a last mark.
// Init gives 12 strobes, the byte requests 2, rejected requests none.
// Per strobe: the wait units (long_wait_ticks each), then an enable high phase and
// an enable low phase (enable_half_ticks each), counted by one 24-bit tick counter,
// then the hand-off of the strobe to the output register. Requests are handled one
// at a time and in_stall stays high until the last strobe is handed off.
// A stalled receiver holds the output register; the sequencer then pauses before
// its next hand-off. Reset (rst_n low, synchronous) returns to idle, clears the
// output valid and restores enable_half_ticks to 40 and long_wait_ticks to 200000.
// cfg_we writes cfg_index 0 (enable_half_ticks) or 1 (long_wait_ticks). The user
// must write them only while idle; the block itself does not enforce this.
module lcd_nibble_write_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lcdnws_pkg::in_item_t        in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lcdnws_pkg::out_item_t       out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lcdnws_pkg::CfgW-1:0] cfg_wdata
);

  lcdnws_pkg::dp_cmd_t cmd;
  lcdnws_pkg::dp_sts_t sts;

  lcdnws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcdnws_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
